>>> rtl/csaw_pkg.sv
// csaw_pkg: shared types and fixed field widths for the centre-out spiral walker
// no dependencies; imported by csaw_step and center_spiral_address_walker
`default_nettype none

package csaw_pkg;

   // widths fixed by the item and register fields
   localparam int unsigned ROW_W   = 5;
   localparam int unsigned COL_W   = 5;
   localparam int unsigned ORDER_W = 11;
   localparam int unsigned GRID_W  = 6;

   // reset value of the grid size register
   localparam logic [GRID_W-1:0] GRID_RESET = 6'd5;

   // leg direction of the spiral; up means row decreasing
   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_UP    = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_DOWN  = 2'd3
   } dir_type;

endpackage

`default_nettype wire

>>> rtl/csaw_step.sv
// csaw_step: shared step unit, moves the walk one position along the spiral
// and checks the new position against the grid; depends on csaw_pkg
`default_nettype none

module csaw_step import csaw_pkg::*; #(
   parameter int unsigned MAX_SIZE = 32
) (
   input  wire logic signed [$clog2(MAX_SIZE)+1:0]   row,
   input  wire logic signed [$clog2(MAX_SIZE)+1:0]   col,
   input  wire dir_type                              dir,
   input  wire logic [$clog2(MAX_SIZE+2):0]          leg_len,
   input  wire logic [$clog2(MAX_SIZE+2):0]          leg_prog,
   input  wire logic [$clog2(MAX_SIZE+1)-1:0]        eff_size,
   output logic signed [$clog2(MAX_SIZE)+1:0]        next_row,
   output logic signed [$clog2(MAX_SIZE)+1:0]        next_col,
   output dir_type                                   next_dir,
   output logic [$clog2(MAX_SIZE+2):0]               next_len,
   output logic [$clog2(MAX_SIZE+2):0]               next_prog,
   output logic                                      next_in_grid
);

   localparam int unsigned CW = $clog2(MAX_SIZE) + 2;
   localparam int unsigned LW = $clog2(MAX_SIZE + 2) + 1;

   logic [LW-1:0] prog_inc;
   logic          leg_done;
   logic [CW-1:0] size_ext;

   // move one position in the current direction
   always_comb begin
      next_row = row;
      next_col = col;
      case (dir)
         DIR_RIGHT: next_col = col + CW'(1);
         DIR_UP:    next_row = row - CW'(1);
         DIR_LEFT:  next_col = col - CW'(1);
         DIR_DOWN:  next_row = row + CW'(1);
         default:   next_col = col;
      endcase
   end

   // leg bookkeeping: turn at the end of a leg, lengthen after up and down legs
   assign prog_inc = leg_prog + LW'(1);
   assign leg_done = (prog_inc >= leg_len);

   always_comb begin
      next_dir  = dir;
      next_len  = leg_len;
      next_prog = prog_inc;
      if (leg_done) begin
         next_prog = '0;
         case (dir)
            DIR_RIGHT: next_dir = DIR_UP;
            DIR_UP: begin
               next_dir = DIR_LEFT;
               next_len = leg_len + LW'(1);
            end
            DIR_LEFT:  next_dir = DIR_DOWN;
            DIR_DOWN: begin
               next_dir = DIR_RIGHT;
               next_len = leg_len + LW'(1);
            end
            default:   next_dir = DIR_RIGHT;
         endcase
      end
   end

   // grid check of the new position
   assign size_ext     = CW'(eff_size);
   assign next_in_grid = !next_row[CW-1] && !next_col[CW-1] &&
                         ($unsigned(next_row) < size_ext) &&
                         ($unsigned(next_col) < size_ext);

endmodule

`default_nettype wire

>>> rtl/center_spiral_address_walker.sv
// center_spiral_address_walker: streams the centre-out spiral order of an N by N grid
// Result: registered when the cell is found and the output register is free, else held
// in S_HOLD; even sizes first step over the off-grid positions in S_WALK.
// Throughput: one item per cycle for odd sizes while the receiver does not stall; even sizes
// stall items while the single step unit walks the skipped positions, one a cycle.
// Reset: grid size 5, the next item gives the centre with number 1; uses csaw_pkg, csaw_step
`default_nettype none

module center_spiral_address_walker import csaw_pkg::*; #(
   parameter int unsigned MAX_SIZE = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_restart,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [ROW_W-1:0]        rsp_row,
   output logic [COL_W-1:0]        rsp_col,
   output logic [ORDER_W-1:0]      rsp_order_number,
   output logic                    rsp_last,
   // grid size register write
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [GRID_W-1:0]  csr_grid_size
);

   localparam int unsigned CW    = $clog2(MAX_SIZE) + 2;
   localparam int unsigned LW    = $clog2(MAX_SIZE + 2) + 1;
   localparam int unsigned SW    = $clog2(MAX_SIZE + 1);
   localparam int unsigned NW    = $clog2(MAX_SIZE * MAX_SIZE + 2);
   localparam int unsigned GCMPW = (GRID_W > SW) ? GRID_W : SW;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_HOLD
   } state_type;

   state_type               state_ff, state_in;
   logic [GRID_W-1:0]       size_ff, size_in;
   logic                    pend_ff, pend_in;
   logic                    started_ff, started_in;
   logic signed [CW-1:0]    row_ff, row_in;
   logic signed [CW-1:0]    col_ff, col_in;
   dir_type                 dir_ff, dir_in;
   logic [LW-1:0]           len_ff, len_in;
   logic [LW-1:0]           prog_ff, prog_in;
   logic [NW-1:0]           num_ff, num_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]        rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]        rsp_col_ff, rsp_col_in;
   logic [ORDER_W-1:0]      rsp_num_ff, rsp_num_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [SW-1:0]           eff_size;
   logic [SW-1:0]           center;
   logic [NW-1:0]           total;
   logic                    do_restart;
   logic                    use_restart;
   logic signed [CW-1:0]    src_row, src_col;
   dir_type                 src_dir;
   logic [LW-1:0]           src_len, src_prog;
   logic [NW-1:0]           src_num;
   logic                    src_started;
   logic signed [CW-1:0]    adv_row, adv_col;
   dir_type                 adv_dir;
   logic [LW-1:0]           adv_len, adv_prog;
   logic                    adv_in_grid;
   logic signed [CW-1:0]    cand_row, cand_col;
   dir_type                 cand_dir;
   logic [LW-1:0]           cand_len, cand_prog;
   logic                    found;
   logic                    out_free;
   logic [NW-1:0]           held_num;

   // effective grid size: zero reads as one, large values saturate
   always_comb begin
      if (size_ff == '0) begin
         eff_size = SW'(1);
      end else if (GCMPW'(size_ff) > GCMPW'(MAX_SIZE)) begin
         eff_size = SW'(MAX_SIZE);
      end else begin
         eff_size = SW'(size_ff);
      end
   end

   assign center = (eff_size - SW'(1)) >> 1;
   assign total  = NW'(eff_size) * NW'(eff_size);

   // handshakes
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // walk source: restart values or the stored walk
   assign do_restart  = pend_ff || req_restart || (num_ff > total);
   assign use_restart = (state_ff == S_IDLE) && do_restart;

   always_comb begin
      if (use_restart) begin
         src_row     = CW'(center);
         src_col     = CW'(center);
         src_dir     = DIR_RIGHT;
         src_len     = LW'(1);
         src_prog    = '0;
         src_num     = NW'(1);
         src_started = 1'b0;
      end else begin
         src_row     = row_ff;
         src_col     = col_ff;
         src_dir     = dir_ff;
         src_len     = len_ff;
         src_prog    = prog_ff;
         src_num     = num_ff;
         src_started = started_ff;
      end
   end

   csaw_step #(
      .MAX_SIZE (MAX_SIZE)
   ) u_step (
      .row          (src_row),
      .col          (src_col),
      .dir          (src_dir),
      .leg_len      (src_len),
      .leg_prog     (src_prog),
      .eff_size     (eff_size),
      .next_row     (adv_row),
      .next_col     (adv_col),
      .next_dir     (adv_dir),
      .next_len     (adv_len),
      .next_prog    (adv_prog),
      .next_in_grid (adv_in_grid)
   );

   // the centre is given without a step on the first item of a walk
   always_comb begin
      if (src_started) begin
         cand_row  = adv_row;
         cand_col  = adv_col;
         cand_dir  = adv_dir;
         cand_len  = adv_len;
         cand_prog = adv_prog;
      end else begin
         cand_row  = src_row;
         cand_col  = src_col;
         cand_dir  = src_dir;
         cand_len  = src_len;
         cand_prog = src_prog;
      end
   end

   assign found    = !src_started || adv_in_grid;
   assign held_num = num_ff - NW'(1);

   // sequencer and next values
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      pend_in      = pend_ff;
      started_in   = started_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      dir_in       = dir_ff;
      len_in       = len_ff;
      prog_in      = prog_ff;
      num_in       = num_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE, S_WALK: begin
            if (state_ff == S_IDLE && csr_valid) begin
               // new size: walk starts over on the next item
               size_in = csr_grid_size;
               pend_in = 1'b1;
            end else if (state_ff == S_WALK || req_valid) begin
               pend_in    = 1'b0;
               started_in = 1'b1;
               row_in     = cand_row;
               col_in     = cand_col;
               dir_in     = cand_dir;
               len_in     = cand_len;
               prog_in    = cand_prog;
               num_in     = src_num;
               if (found) begin
                  num_in = src_num + NW'(1);
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in   = ROW_W'(cand_row);
                     rsp_col_in   = COL_W'(cand_col);
                     rsp_num_in   = ORDER_W'(src_num);
                     rsp_last_in  = (src_num == total);
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_HOLD;
                  end
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_HOLD: begin
            // cell found, waiting for the output register
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = ROW_W'(row_ff);
               rsp_col_in   = COL_W'(col_ff);
               rsp_num_in   = ORDER_W'(held_num);
               rsp_last_in  = (held_num == total);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= GRID_RESET;
         pend_ff      <= 1'b1;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         pend_ff      <= pend_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      dir_ff      <= dir_in;
      len_ff      <= len_in;
      prog_ff     <= prog_in;
      num_ff      <= num_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row          = rsp_row_ff;
   assign rsp_col          = rsp_col_ff;
   assign rsp_order_number = rsp_num_ff;
   assign rsp_last         = rsp_last_ff;

   // checks
   a_hold_means_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD |-> rsp_valid_ff)
      else $error("pending cell without an occupied output register");

   a_walk_started: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> started_ff && !pend_ff)
      else $error("stepping a walk that has not started");

   a_number_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_num_ff != '0)
      else $error("cell given with order number zero");

   a_last_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_num_ff == ORDER_W'(total))
      else $error("last cell number does not match grid area");

endmodule

`default_nettype wire

>>> test/spiral_order_check.sv
// spiral_order_check: watches the walker's item, result and grid size channels,
// predicts each visited cell of the centre-out spiral and compares field by field
// depends on csaw_pkg; instantiated beside the walker by center_spiral_address_walker_test
module spiral_order_check import csaw_pkg::*; #(
   parameter int unsigned GRID_MAX = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic               req_restart,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [ROW_W-1:0]   rsp_row,
   input  wire logic [COL_W-1:0]   rsp_col,
   input  wire logic [ORDER_W-1:0] rsp_order_number,
   input  wire logic               rsp_last,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [GRID_W-1:0]  csr_grid_size,
   output int                      mismatches,
   output int                      pending,
   output int                      checked,
   output int                      walks
);

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [ORDER_W-1:0] order;
      logic               last;
   } visit_type;

   // own copy of the walk state and the grid size register
   logic [GRID_W-1:0] grid_reg;
   int                walk_row;
   int                walk_col;
   dir_type           heading;
   int                leg_len;
   int                leg_step;
   int                next_ord;
   bit                centre_given;

   visit_type         want_visits[$];

   // grid side in use: zero counts as one, oversize saturates
   function automatic int side();
      int n;
      n = int'(grid_reg);
      if (n == 0) n = 1;
      if (n > int'(GRID_MAX)) n = int'(GRID_MAX);
      return n;
   endfunction

   function automatic void begin_walk();
      int c;
      c = (side() - 1) / 2;
      walk_row     = c;
      walk_col     = c;
      heading      = DIR_RIGHT;
      leg_len      = 1;
      leg_step     = 0;
      next_ord     = 1;
      centre_given = 1'b0;
   endfunction

   // one position along the current leg; legs grow after up and down legs
   function automatic void take_step();
      case (heading)
         DIR_RIGHT: walk_col++;
         DIR_UP:    walk_row--;
         DIR_LEFT:  walk_col--;
         default:   walk_row++;
      endcase
      leg_step++;
      if (leg_step >= leg_len) begin
         leg_step = 0;
         case (heading)
            DIR_RIGHT: heading = DIR_UP;
            DIR_UP:    heading = DIR_LEFT;
            DIR_LEFT:  heading = DIR_DOWN;
            default:   heading = DIR_RIGHT;
         endcase
         if (heading == DIR_RIGHT || heading == DIR_LEFT) leg_len++;
      end
   endfunction

   function automatic bit on_grid(input int n);
      return walk_row >= 0 && walk_row < n && walk_col >= 0 && walk_col < n;
   endfunction

   // next cell of the spiral for one item
   function automatic visit_type next_visit(input logic restart);
      int        n;
      int        total;
      int        guard;
      visit_type v;
      n     = side();
      total = n * n;
      if (restart || next_ord > total) begin_walk();
      if (centre_given) begin
         guard = 16 * (int'(GRID_MAX) + 4) * (int'(GRID_MAX) + 4);
         do begin
            take_step();
            guard--;
         end while (!on_grid(n) && guard != 0);
         if (!on_grid(n)) begin_walk();
      end
      centre_given = 1'b1;
      v.row   = walk_row[ROW_W-1:0];
      v.col   = walk_col[COL_W-1:0];
      v.order = next_ord[ORDER_W-1:0];
      v.last  = (next_ord == total);
      next_ord++;
      return v;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
      mismatches++;
   endtask

   // results are taken before items, so a result never matches its own item's edge
   always @(posedge clock) begin
      visit_type w;
      if (reset) begin
         grid_reg = GRID_RESET;
         begin_walk();
         want_visits.delete();
      end else begin
         // compare an accepted result with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (want_visits.size() == 0) begin
               report("unexpected result order", int'(rsp_order_number), 0);
            end else begin
               w = want_visits.pop_front();
               if (rsp_row !== w.row) report("row", int'(rsp_row), int'(w.row));
               if (rsp_col !== w.col) report("col", int'(rsp_col), int'(w.col));
               if (rsp_order_number !== w.order)
                  report("order_number", int'(rsp_order_number), int'(w.order));
               if (rsp_last !== w.last) report("last", int'(rsp_last), int'(w.last));
               if (w.last) walks++;
            end
            checked++;
         end
         // predict an accepted item
         if (req_valid && !req_stall) want_visits.push_back(next_visit(req_restart));
         // grid size write starts the walk over
         if (csr_valid && csr_ready) begin
            grid_reg = csr_grid_size;
            begin_walk();
         end
      end
      pending <= want_visits.size();
   end

endmodule

>>> test/center_spiral_address_walker_test.sv
// center_spiral_address_walker_test: clock, reset and stimulus for the spiral walker,
// with bursty items, a patterned receiver stall and the final verdict
// depends on csaw_pkg, center_spiral_address_walker and spiral_order_check
module center_spiral_address_walker_test;
   import csaw_pkg::*;

   localparam int ITEM_TARGET = 1600;
   localparam int HOLD_CYCLES = 300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [ROW_W-1:0]   rsp_row;
   logic [COL_W-1:0]   rsp_col;
   logic [ORDER_W-1:0] rsp_order_number;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [GRID_W-1:0]  csr_grid_size = GRID_RESET;

   int mismatches;
   int pending;
   int checked;
   int walks;

   int items_sent = 0;
   int grid_writes = 0;
   int burst_left = 0;
   int hold_count = 0;
   bit hold_request = 1'b0;

   center_spiral_address_walker u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row          (rsp_row),
      .rsp_col          (rsp_col),
      .rsp_order_number (rsp_order_number),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_grid_size    (csr_grid_size)
   );

   spiral_order_check u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row          (rsp_row),
      .rsp_col          (rsp_col),
      .rsp_order_number (rsp_order_number),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_grid_size    (csr_grid_size),
      .mismatches       (mismatches),
      .pending          (pending),
      .checked          (checked),
      .walks            (walks)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #(8 * 800000);
      $display("timeout: %0d items sent, %0d results outstanding", items_sent, pending);
      $display("DONE: errors detected");
      $finish;
   end

   // receiver stall patterns, with a long hold-off on request
   initial begin
      int mode;
      int stretch;
      int cyc;
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (cyc = 0; cyc < HOLD_CYCLES; cyc++) @(posedge clock);
            hold_request = 1'b0;
            hold_count++;
         end else begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 120);
            for (cyc = 0; cyc < stretch; cyc++) begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= cyc[0];
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // offer one item, in bursts with random gaps between them
   task automatic send_item(input logic restart);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_grid(input logic [GRID_W-1:0] size);
      drain();
      csr_valid     <= 1'b1;
      csr_grid_size <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      grid_writes++;
   endtask

   // stimulus and verdict
   initial begin
      int                i;
      int                n;
      int                count;
      int                noisy;
      logic [GRID_W-1:0] size;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size: first cells, a restart mid-walk
      send_item(1'b0);
      send_item(1'b0);
      send_item(1'b0);
      send_item(1'b1);
      // size one: centre every time, always last
      write_grid(6'd1);
      send_item(1'b0);
      send_item(1'b1);
      send_item(1'b0);
      // size zero behaves as size one
      write_grid(6'd0);
      send_item(1'b0);
      send_item(1'b0);
      // even size: off-grid skips and wrap past the last cell
      write_grid(6'd2);
      for (i = 0; i < 5; i++) send_item(1'b0);
      send_item(1'b1);
      // oversize saturates
      write_grid(6'd63);
      send_item(1'b0);
      send_item(1'b0);
      send_item(1'b1);
      write_grid(6'd33);
      send_item(1'b0);

      // full walk of the largest grid while the receiver holds off for a stretch
      write_grid(6'd32);
      hold_request = 1'b1;
      for (i = 0; i < 32 * 32 + 2; i++) send_item(1'b0);

      // random sizes, mostly whole walks with the odd restart, some noisy phases
      while (items_sent < ITEM_TARGET) begin
         noisy = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 9))
            0:       size = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
            1:       size = 6'($urandom_range(13, 32));
            default: size = 6'($urandom_range(1, 12));
         endcase
         write_grid(size);
         n = (size == 0) ? 1 : ((size > 32) ? 32 : int'(size));
         count = (n > 12) ? $urandom_range(5, 60) : n * n + $urandom_range(0, 2 * n);
         for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 199) == 0) drain();
            if (noisy) send_item(1'($urandom_range(0, 1)));
            else send_item($urandom_range(0, 63) == 0);
         end
      end

      drain();
      repeat (64) @(posedge clock);
      $display("covered %0d items over %0d grid size writes, %0d receiver hold-offs",
               items_sent, grid_writes, hold_count);
      $display("checked %0d results, %0d complete walks ended on the last cell", checked, walks);
      if (mismatches == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
